// ===== sv/sorted_key_table_search_hash_macros.svh =====
// assertion helpers shared by the rtl
`ifndef SORTED_KEY_TABLE_SEARCH_HASH_MACROS_SVH
`define SORTED_KEY_TABLE_SEARCH_HASH_MACROS_SVH

// condition must hold in the same cycle
`define SKTS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// condition must hold in the next cycle
`define SKTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/skts_pkg.sv =====
`default_nettype none
package skts_pkg;

	// field widths
	localparam int KEY_W       = 27;
	localparam int FUNC_W      = 2;
	localparam int STATUS_W    = 2;
	localparam int INDEX_W     = 7;
	localparam int ADDR_W      = 10;
	localparam int S_DATA_W    = 32;
	localparam int M_DATA_W    = 24;

	// folding hash: key / 100000, (key mod 100000) / 100, key mod 100, sum mod 1000
	localparam int TOP_DIV     = 100000;
	localparam int MID_DIV     = 100;
	localparam int HASH_MOD    = 1000;
	localparam int TOP_QW      = 11;
	localparam int MID_QW      = 10;
	localparam int LOW_W       = 7;
	localparam int REM_W       = 17;
	localparam int SUM_W       = 12;

	// reciprocals: x / d == (x * ceil(2^s / d)) >> s over the whole input range
	localparam int TOP_SHIFT   = 44;
	localparam int TOP_RW      = 28;
	localparam int TOP_PW      = TOP_SHIFT + TOP_QW;
	localparam logic [TOP_RW-1:0] TOP_RECIP = 28'd175921861;
	localparam int MID_SHIFT   = 24;
	localparam int MID_RW      = 18;
	localparam int MID_PW      = MID_SHIFT + MID_QW;
	localparam logic [MID_RW-1:0] MID_RECIP = 18'd167773;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_DELETE = 2'd1,
		FUNC_SEARCH = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK        = 2'd0,
		STATUS_FULL      = 2'd1,
		STATUS_EMPTY     = 2'd2,
		STATUS_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_INSERT,
		ST_DELETE,
		ST_PSEL,
		ST_PCMP,
		ST_HWAIT,
		ST_RESP
	} state_t;

	typedef enum logic [2:0] {
		H_IDLE,
		H_TOP,
		H_REM,
		H_MID,
		H_LOW,
		H_SUM,
		H_DONE
	} hash_state_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_CAPTURE,
		CELL_SHIFT_UP,
		CELL_SHIFT_DOWN
	} cell_op_t;

	typedef struct packed {
		cell_op_t         op;
		logic [KEY_W-1:0] key;
	} cell_cmd_t;

	typedef struct packed {
		logic             start;
		logic [KEY_W-1:0] key;
	} hash_req_t;

	typedef struct packed {
		logic              done;
		logic [ADDR_W-1:0] addr;
	} hash_res_t;

endpackage
`default_nettype wire

// ===== sv/skts_cell.sv =====
`default_nettype none
module skts_cell #(
	parameter int INDEX = 0,
	parameter int CNT_W = 8
) (
	input  logic                       clk,
	input  skts_pkg::cell_cmd_t        cmd,
	input  logic [CNT_W-1:0]           count,
	input  logic [skts_pkg::KEY_W-1:0] left_key,
	input  logic                       left_gt,
	input  logic [skts_pkg::KEY_W-1:0] right_key,
	output logic [skts_pkg::KEY_W-1:0] key,
	output logic                       gt,
	output logic                       eq
);
	import skts_pkg::*;

	localparam logic [CNT_W-1:0] POS = CNT_W'(INDEX);

	logic [KEY_W-1:0] key_q;
	logic             gt_q;
	logic             ge_q;
	logic             eq_q;
	logic             occ;

	// slot holds a live key
	assign occ = POS < count;

	// compare against the request key, then shift with the neighbours
	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_CAPTURE: begin
				gt_q <= !occ || (key_q > cmd.key);
				ge_q <= key_q >= cmd.key;
				eq_q <= occ && (key_q == cmd.key);
			end
			CELL_SHIFT_UP: begin
				if (gt_q) key_q <= left_gt ? left_key : cmd.key;
			end
			CELL_SHIFT_DOWN: begin
				if (ge_q) key_q <= right_key;
			end
			default: begin
			end
		endcase
	end

	assign key = key_q;
	assign gt  = gt_q;
	assign eq  = eq_q;

endmodule
`default_nettype wire

// ===== sv/skts_hash.sv =====
`default_nettype none
module skts_hash (
	input  logic                clk,
	input  logic                arst_n,
	input  skts_pkg::hash_req_t req,
	output skts_pkg::hash_res_t res
);
	import skts_pkg::*;

	hash_state_t       state_q;
	hash_state_t       state_d;
	logic [KEY_W-1:0]  r_q;
	logic [TOP_QW-1:0] top_q;
	logic [REM_W-1:0]  rem_q;
	logic [MID_QW-1:0] mid_q;
	logic [LOW_W-1:0]  low_q;
	logic [ADDR_W-1:0] addr_q;
	logic [TOP_PW-1:0] top_prod;
	logic [KEY_W-1:0]  top_back;
	logic [REM_W-1:0]  rem_d;
	logic [MID_PW-1:0] mid_prod;
	logic [LOW_W-1:0]  low_d;
	logic [SUM_W-1:0]  sum;
	logic [ADDR_W-1:0] addr_next;

	// top part by reciprocal multiplication, then the remainder below 100000
	assign top_prod = TOP_PW'(r_q) * TOP_PW'(TOP_RECIP);
	assign top_back = KEY_W'(top_q) * KEY_W'(TOP_DIV);
	assign rem_d    = REM_W'(r_q - top_back);

	// middle part by reciprocal multiplication, then the last two digits
	assign mid_prod = MID_PW'(rem_q) * MID_PW'(MID_RECIP);
	assign low_d    = LOW_W'(rem_q - REM_W'(mid_q) * REM_W'(MID_DIV));

	// fold and reduce mod 1000, the sum stays below three times the modulus
	assign sum = SUM_W'(top_q) + SUM_W'(mid_q) + SUM_W'(low_q);
	always_comb begin
		if (sum >= SUM_W'(2 * HASH_MOD)) addr_next = ADDR_W'(sum - SUM_W'(2 * HASH_MOD));
		else if (sum >= SUM_W'(HASH_MOD)) addr_next = ADDR_W'(sum - SUM_W'(HASH_MOD));
		else addr_next = ADDR_W'(sum);
	end

	// next state
	always_comb begin
		state_d = state_q;
		if (req.start) begin
			state_d = H_TOP;
		end else begin
			unique case (state_q)
				H_IDLE: state_d = H_IDLE;
				H_TOP:  state_d = H_REM;
				H_REM:  state_d = H_MID;
				H_MID:  state_d = H_LOW;
				H_LOW:  state_d = H_SUM;
				H_SUM:  state_d = H_DONE;
				H_DONE: state_d = H_DONE;
				default: state_d = H_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// one step of the fold per cycle
	always_ff @(posedge clk) begin
		if (req.start) r_q <= req.key;
		unique case (state_q)
			H_TOP: top_q <= TOP_QW'(top_prod >> TOP_SHIFT);
			H_REM: rem_q <= rem_d;
			H_MID: mid_q <= MID_QW'(mid_prod >> MID_SHIFT);
			H_LOW: low_q <= low_d;
			H_SUM: addr_q <= addr_next;
			default: begin
			end
		endcase
	end

	// outputs
	always_comb begin
		res.done = state_q == H_DONE;
		res.addr = addr_q;
	end

endmodule
`default_nettype wire

// ===== sv/sorted_key_table_search_hash.sv =====
// sorted key table with binary search and folding hash
//
// requests come in on the s_ channel: s_tuser carries the operation (insert,
// delete, search), s_tdata the 27-bit key. every request gives exactly one
// response on the m_ channel: m_tuser carries the status, m_tdata the
// found index and the hash address (both zero unless a search hits).
// keys sit in a row of cells, one key per cell, kept in ascending order.
// insert and delete compare in every cell at once in the decide state,
// then shift the row by one place in the insert or delete state before the
// response state, which registers m_tvalid (a full or empty table or an
// unused code goes from decide straight to the response state). search
// walks the midpoint probes, each a select and a compare state, while the
// hash unit folds the key alongside; a hit waits for the hash to be done.
// 128 entries need at most 8 probes. one request is in flight at a time
// and the next is taken the cycle after its response is loaded; the
// response register lets it in while a response still waits on a stalled
// m_tready, the next response then waiting in the result registers until
// m_tready frees it. reset empties the table at once; cells need no clearing.
`default_nettype none
`include "sorted_key_table_search_hash_macros.svh"
module sorted_key_table_search_hash #(
	parameter int TABLE_DEPTH = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [skts_pkg::S_DATA_W-1:0] s_tdata,  // [26:0] key, [31:27] zero
	input  logic [skts_pkg::FUNC_W-1:0]   s_tuser,  // [1:0] func
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [skts_pkg::M_DATA_W-1:0] m_tdata,  // [6:0] found_index, [16:7] hash_address
	output logic [skts_pkg::STATUS_W-1:0] m_tuser   // [1:0] status
);
	import skts_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	// control state
	state_t            state_q;
	state_t            state_d;
	logic [CNT_W-1:0]  count_q;
	logic              m_tvalid_q;

	// request and search registers
	func_t             func_q;
	logic [KEY_W-1:0]  key_q;
	logic [CNT_W-1:0]  lo_q;
	logic [CNT_W-1:0]  hb_q;
	logic [IDX_W-1:0]  mid_q;
	logic [KEY_W-1:0]  probe_q;
	status_t           res_status_q;
	logic [INDEX_W-1:0] res_index_q;
	logic [ADDR_W-1:0] res_addr_q;
	status_t           out_status_q;
	logic [INDEX_W-1:0] out_index_q;
	logic [ADDR_W-1:0] out_addr_q;

	// control from the output decoder
	cell_op_t          cell_op;
	logic              hash_start;
	logic              search_init;
	logic              probe_load;
	logic              lo_update;
	logic              hb_update;
	logic              cnt_inc;
	logic              cnt_dec;
	logic              res_load;
	status_t           res_status;
	logic              res_hit;
	logic              out_load;

	// cell row
	cell_cmd_t          cmd;
	logic [KEY_W-1:0]   cell_key [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] gt_vec;
	logic [TABLE_DEPTH-1:0] eq_vec;
	hash_req_t          hreq;
	hash_res_t          hres;

	logic               full;
	logic               empty;
	logic               found;
	logic               probing;
	logic [CNT_W:0]     mid_sum;
	logic [IDX_W-1:0]   mid;

	assign full    = count_q == CNT_W'(TABLE_DEPTH);
	assign empty   = count_q == '0;
	assign found   = |eq_vec;
	assign probing = lo_q < hb_q;

	// midpoint of lo .. hb-1
	assign mid_sum = {1'b0, lo_q} + {1'b0, hb_q} - 1'b1;
	assign mid     = mid_sum[IDX_W:1];

	assign cmd.op  = cell_op;
	assign cmd.key = key_q;

	// row of key cells
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic [KEY_W-1:0] lkey;
		logic             lgt;
		logic [KEY_W-1:0] rkey;
		if (i == 0) begin : g_first
			assign lkey = '0;
			assign lgt  = 1'b0;
		end else begin : g_mid
			assign lkey = cell_key[i-1];
			assign lgt  = gt_vec[i-1];
		end
		if (i == TABLE_DEPTH - 1) begin : g_last
			assign rkey = cell_key[i];
		end else begin : g_inner
			assign rkey = cell_key[i+1];
		end
		skts_cell #(
			.INDEX (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.count     (count_q),
			.left_key  (lkey),
			.left_gt   (lgt),
			.right_key (rkey),
			.key       (cell_key[i]),
			.gt        (gt_vec[i]),
			.eq        (eq_vec[i])
		);
	end

	// folding hash of the search key
	assign hreq.start = hash_start;
	assign hreq.key   = key_q;

	skts_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (hreq),
		.res    (hres)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_DECIDE;
			ST_DECIDE: begin
				unique case (func_q)
					FUNC_INSERT: state_d = full ? ST_RESP : ST_INSERT;
					FUNC_DELETE: state_d = empty ? ST_RESP : ST_DELETE;
					FUNC_SEARCH: state_d = empty ? ST_RESP : ST_PSEL;
					default:     state_d = ST_RESP;
				endcase
			end
			ST_INSERT: state_d = ST_RESP;
			ST_DELETE: state_d = ST_RESP;
			ST_PSEL:   state_d = probing ? ST_PCMP : ST_RESP;
			ST_PCMP:   state_d = (probe_q == key_q) ? ST_HWAIT : ST_PSEL;
			ST_HWAIT:  if (hres.done) state_d = ST_RESP;
			ST_RESP:   if (out_load) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		s_tready    = 1'b0;
		cell_op     = CELL_HOLD;
		hash_start  = 1'b0;
		search_init = 1'b0;
		probe_load  = 1'b0;
		lo_update   = 1'b0;
		hb_update   = 1'b0;
		cnt_inc     = 1'b0;
		cnt_dec     = 1'b0;
		res_load    = 1'b0;
		res_status  = STATUS_OK;
		res_hit     = 1'b0;
		out_load    = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_DECIDE: begin
				cell_op = CELL_CAPTURE;
				unique case (func_q)
					FUNC_INSERT: begin
						if (full) begin
							res_load   = 1'b1;
							res_status = STATUS_FULL;
						end
					end
					FUNC_DELETE: begin
						if (empty) begin
							res_load   = 1'b1;
							res_status = STATUS_EMPTY;
						end
					end
					FUNC_SEARCH: begin
						if (empty) begin
							res_load   = 1'b1;
							res_status = STATUS_EMPTY;
						end else begin
							search_init = 1'b1;
							hash_start  = 1'b1;
						end
					end
					default: res_load = 1'b1;
				endcase
			end
			ST_INSERT: begin
				cell_op  = CELL_SHIFT_UP;
				cnt_inc  = 1'b1;
				res_load = 1'b1;
			end
			ST_DELETE: begin
				res_load = 1'b1;
				if (found) begin
					cell_op = CELL_SHIFT_DOWN;
					cnt_dec = 1'b1;
				end else begin
					res_status = STATUS_NOT_FOUND;
				end
			end
			ST_PSEL: begin
				if (probing) begin
					probe_load = 1'b1;
				end else begin
					res_load   = 1'b1;
					res_status = STATUS_NOT_FOUND;
				end
			end
			ST_PCMP: begin
				if (probe_q < key_q) lo_update = 1'b1;
				else if (probe_q > key_q) hb_update = 1'b1;
			end
			ST_HWAIT: begin
				if (hres.done) begin
					res_load = 1'b1;
					res_hit  = 1'b1;
				end
			end
			ST_RESP: out_load = !m_tvalid_q || m_tready;
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_inc) count_q <= count_q + 1'b1;
			else if (cnt_dec) count_q <= count_q - 1'b1;
			if (out_load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// request, search and response registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_q <= func_t'(s_tuser);
			key_q  <= s_tdata[KEY_W-1:0];
		end
		if (search_init) begin
			lo_q <= '0;
			hb_q <= count_q;
		end
		if (probe_load) begin
			probe_q <= cell_key[mid];
			mid_q   <= mid;
		end
		if (lo_update) lo_q <= CNT_W'(mid_q) + 1'b1;
		if (hb_update) hb_q <= CNT_W'(mid_q);
		if (res_load) begin
			res_status_q <= res_status;
			res_index_q  <= res_hit ? INDEX_W'(mid_q) : '0;
			res_addr_q   <= res_hit ? hres.addr : '0;
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_index_q  <= res_index_q;
			out_addr_q   <= res_addr_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {{(M_DATA_W - INDEX_W - ADDR_W){1'b0}}, out_addr_q, out_index_q};

	// checks
	`SKTS_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(TABLE_DEPTH), "entry count above depth")
	`SKTS_ASSERT_NOW(a_no_insert_full, cell_op == CELL_SHIFT_UP, !full, "insert shift on a full table")
	`SKTS_ASSERT_NOW(a_no_delete_empty, cell_op == CELL_SHIFT_DOWN, !empty, "delete shift on an empty table")
	`SKTS_ASSERT_NOW(a_probe_in_range, probe_load, CNT_W'(mid) < count_q, "probe beyond live entries")
	`SKTS_ASSERT_NEXT(a_count_step, cnt_inc || cnt_dec, count_q != $past(count_q), "entry count did not move")

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
	import skts_pkg::*;

	localparam int DEPTH       = 128;
	localparam int POOL_SIZE   = 48;
	localparam int RAND_ITEMS  = 1300;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 64;
	localparam logic [KEY_W-1:0] KEY_TOP_DEC = KEY_W'(99999999);
	localparam logic [KEY_W-1:0] KEY_ALL_ONE = {KEY_W{1'b1}};

	typedef struct {
		func_t            func;
		logic [KEY_W-1:0] key;
		bit               drain;   // hold off until all responses are back
	} table_req_t;

	typedef struct {
		status_t            status;
		logic [INDEX_W-1:0] index;
		logic [ADDR_W-1:0]  addr;
	} table_resp_t;

	typedef enum {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata  = '0;
	logic [FUNC_W-1:0]   s_tuser  = FUNC_INSERT;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0] m_tuser;

	table_req_t  req_backlog[$];
	table_resp_t resp_due[$];
	int          n_faults    = 0;
	int          cycle_count = 0;

	// shadow of the sorted table
	logic [KEY_W-1:0] shadow_keys[DEPTH];
	int               shadow_count = 0;

	logic [KEY_W-1:0] key_pool[POOL_SIZE];

	sorted_key_table_search_hash #(
		.TABLE_DEPTH(DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_fault(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		n_faults++;
	endtask

	// top, middle and last two decimal digits summed, mod 1000
	function automatic logic [ADDR_W-1:0] fold_address(input logic [KEY_W-1:0] k);
		int unsigned top;
		int unsigned mid;
		int unsigned low;
		top = k / TOP_DIV;
		mid = (k % TOP_DIV) / MID_DIV;
		low = k % MID_DIV;
		return ADDR_W'((top + mid + low) % HASH_MOD);
	endfunction

	// apply one request to the shadow table and give the response it must cause
	function automatic table_resp_t table_apply(input func_t func, input logic [KEY_W-1:0] k);
		table_resp_t r;
		int          pos;
		int          lo;
		int          hi;
		int          mid;
		r.status = STATUS_OK;
		r.index  = '0;
		r.addr   = '0;
		case (func)
			FUNC_INSERT: begin
				if (shadow_count >= DEPTH) begin
					r.status = STATUS_FULL;
				end else begin
					pos = 0;
					while (pos < shadow_count && shadow_keys[pos] <= k)
						pos++;
					for (int j = shadow_count; j > pos; j--)
						shadow_keys[j] = shadow_keys[j-1];
					shadow_keys[pos] = k;
					shadow_count++;
				end
			end
			FUNC_DELETE: begin
				if (shadow_count == 0) begin
					r.status = STATUS_EMPTY;
				end else begin
					pos = 0;
					while (pos < shadow_count && shadow_keys[pos] != k)
						pos++;
					if (pos == shadow_count) begin
						r.status = STATUS_NOT_FOUND;
					end else begin
						for (int j = pos; j < shadow_count - 1; j++)
							shadow_keys[j] = shadow_keys[j+1];
						shadow_count--;
					end
				end
			end
			FUNC_SEARCH: begin
				if (shadow_count == 0) begin
					r.status = STATUS_EMPTY;
				end else begin
					// midpoint probes, first hit wins among duplicates
					r.status = STATUS_NOT_FOUND;
					lo = 0;
					hi = shadow_count - 1;
					while (lo <= hi && r.status != STATUS_OK) begin
						mid = lo + (hi - lo) / 2;
						if (shadow_keys[mid] == k) begin
							r.status = STATUS_OK;
							r.index  = INDEX_W'(mid);
							r.addr   = fold_address(k);
						end else if (shadow_keys[mid] < k) begin
							lo = mid + 1;
						end else begin
							hi = mid - 1;
						end
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic void push_req(input func_t f, input logic [KEY_W-1:0] k, input bit d);
		table_req_t t;
		t.func  = f;
		t.key   = k;
		t.drain = d;
		req_backlog.push_back(t);
	endfunction

	// mostly pool keys so that deletes and searches hit, now and then a fresh one
	function automatic logic [KEY_W-1:0] pick_key();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 3)
			key_pool[$urandom_range(3, POOL_SIZE - 1)] = KEY_W'($urandom_range(0, 99999999));
		if (roll < 75)
			return key_pool[$urandom_range(0, POOL_SIZE - 1)];
		else if (roll < 85)
			return KEY_W'($urandom) & KEY_ALL_ONE;
		else
			return KEY_W'($urandom_range(0, 99999999));
	endfunction

	// stimulus, reset and end of run
	initial begin
		mix_t  mix;
		int    seg;
		int    seg_len;
		int    ins_pct;
		int    del_pct;
		int    roll;
		func_t f;

		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = KEY_W'($urandom_range(0, 99999999));
		key_pool[0] = '0;
		key_pool[1] = KEY_TOP_DEC;
		key_pool[2] = KEY_ALL_ONE;

		// empty table, unused code, extremes, duplicates, misses
		push_req(FUNC_DELETE, KEY_W'(5), 1'b0);
		push_req(FUNC_SEARCH, KEY_W'(5), 1'b0);
		push_req(FUNC_NONE, KEY_ALL_ONE, 1'b0);
		push_req(FUNC_INSERT, '0, 1'b0);
		push_req(FUNC_INSERT, KEY_TOP_DEC, 1'b0);
		push_req(FUNC_INSERT, KEY_ALL_ONE, 1'b0);
		push_req(FUNC_INSERT, KEY_W'(12345678), 1'b0);
		push_req(FUNC_INSERT, KEY_W'(12345678), 1'b0);
		push_req(FUNC_INSERT, KEY_W'(27'h2AAAAAA), 1'b0);
		push_req(FUNC_SEARCH, '0, 1'b0);
		push_req(FUNC_SEARCH, KEY_TOP_DEC, 1'b0);
		push_req(FUNC_SEARCH, KEY_ALL_ONE, 1'b0);
		push_req(FUNC_SEARCH, KEY_W'(12345678), 1'b0);
		push_req(FUNC_SEARCH, KEY_W'(27'h2AAAAAA), 1'b0);
		push_req(FUNC_SEARCH, KEY_W'(55555555), 1'b0);
		push_req(FUNC_DELETE, KEY_W'(77), 1'b0);
		push_req(FUNC_DELETE, KEY_W'(12345678), 1'b1);
		push_req(FUNC_SEARCH, KEY_W'(12345678), 1'b0);
		push_req(FUNC_NONE, '0, 1'b0);
		push_req(FUNC_DELETE, '0, 1'b0);
		push_req(FUNC_DELETE, KEY_TOP_DEC, 1'b0);
		push_req(FUNC_DELETE, KEY_W'(12345678), 1'b0);
		push_req(FUNC_DELETE, KEY_ALL_ONE, 1'b0);
		push_req(FUNC_DELETE, KEY_W'(27'h2AAAAAA), 1'b0);
		push_req(FUNC_SEARCH, '0, 1'b0);

		// random phases: fill to full, drain, then mixed
		seg = 0;
		while (req_backlog.size() < RAND_ITEMS + 25) begin
			if (seg == 0)
				mix = MIX_GROW;
			else if (seg == 1)
				mix = MIX_SHRINK;
			else
				mix = mix_t'($urandom_range(0, 2));
			seg_len = (seg < 2) ? 260 : $urandom_range(40, 160);
			case (mix)
				MIX_GROW:   begin ins_pct = 75; del_pct = 10; end
				MIX_SHRINK: begin ins_pct = 10; del_pct = 75; end
				default:    begin ins_pct = 34; del_pct = 30; end
			endcase
			for (int j = 0; j < seg_len; j++) begin
				roll = $urandom_range(0, 99);
				if (roll < ins_pct)
					f = FUNC_INSERT;
				else if (roll < ins_pct + del_pct)
					f = FUNC_DELETE;
				else if (roll < 98)
					f = FUNC_SEARCH;
				else
					f = FUNC_NONE;
				push_req(f, pick_key(), j == 0);
			end
			seg++;
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (req_backlog.size() != 0 || s_tvalid || resp_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_faults == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// request driver: bursts with random gaps
	always @(posedge clk) begin : drive
		table_resp_t due;
		table_req_t  nxt;
		static int   gap_left   = 0;
		static int   burst_left = 0;
		static func_t            cur_func;
		static logic [KEY_W-1:0] cur_key;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				due = table_apply(cur_func, cur_key);
				resp_due.push_back(due);
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (req_backlog.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (req_backlog[0].drain && resp_due.size() != 0) begin
					s_tvalid <= 1'b0;
				end else begin
					nxt = req_backlog.pop_front();
					cur_func = nxt.func;
					cur_key  = nxt.key;
					s_tvalid <= 1'b1;
					s_tdata  <= S_DATA_W'(nxt.key);
					s_tuser  <= nxt.func;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 12);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
		end
	end

	// response ready: switches between always ready, random and long stalls
	always @(posedge clk) begin : sink
		static int stall_mode = 0;
		static int mode_left  = 0;
		static int stall_run  = 0;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left  = $urandom_range(50, 250);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 9) < 6);
				default: begin
					if (stall_run > 0) begin
						stall_run--;
						m_tready <= 1'b0;
					end else begin
						m_tready <= 1'b1;
						if ($urandom_range(0, 4) == 0)
							stall_run = $urandom_range(1, 12);
					end
				end
			endcase
		end
	end

	// response monitor
	always @(posedge clk) begin : watch
		table_resp_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (resp_due.size() == 0) begin
				report_fault($sformatf("response with none due, status %0d", m_tuser));
			end else begin
				want = resp_due.pop_front();
				if (m_tuser != want.status)
					report_fault($sformatf("status %0d, want %0d", m_tuser, want.status));
				if (m_tdata[INDEX_W-1:0] != want.index)
					report_fault($sformatf("index %0d, want %0d",
						m_tdata[INDEX_W-1:0], want.index));
				if (m_tdata[INDEX_W +: ADDR_W] != want.addr)
					report_fault($sformatf("hash address %0d, want %0d",
						m_tdata[INDEX_W +: ADDR_W], want.addr));
				if (m_tdata[M_DATA_W-1:INDEX_W+ADDR_W] != '0)
					report_fault($sformatf("padding bits set, tdata %h", m_tdata));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/skts_pkg.sv
sv/skts_cell.sv
sv/skts_hash.sv
sv/sorted_key_table_search_hash.sv
tb/sv/tb_top.sv
